@@ rtl/gaussian_pyramid_reduce_2x_unit_defines.svh @@
// assertion macros shared by the pyramid reduce rtl
`ifndef GAUSSIAN_PYRAMID_REDUCE_2X_UNIT_DEFINES_SVH
`define GAUSSIAN_PYRAMID_REDUCE_2X_UNIT_DEFINES_SVH

// same-cycle implication, checked on clk, off while arst_n is low
`define GPR2X_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GPR2X_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/gpr2x_pkg.sv @@
// shared types and constants of the pyramid reduce block
package gpr2x_pkg;

	localparam int PIX_W     = 8;
	localparam int CFG_W     = 11;
	localparam int ROW_CNT_W = 10;
	localparam int DST_IDX_W = 9;
	localparam int SUM_W     = 12;
	localparam int APB_DW    = 32;
	localparam int APB_AW    = 3;

	localparam logic [CFG_W-1:0] DIM_MIN      = 11'd8;
	localparam logic [CFG_W-1:0] HEIGHT_MAX   = 11'd1024;
	localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

	// register index, taken from paddr[2]
	localparam logic REG_SRC_WIDTH  = 1'b0;
	localparam logic REG_SRC_HEIGHT = 1'b1;

	// one destination pixel plus the edge copies it must produce
	typedef struct packed {
		logic [PIX_W-1:0]     value;
		logic [DST_IDX_W-1:0] row;
		logic [DST_IDX_W-1:0] col;
		logic [DST_IDX_W-1:0] last_row;
		logic [DST_IDX_W-1:0] last_col;
		logic                 edge_col;
		logic                 edge_row;
	} bundle_t;

endpackage

@@ rtl/gpr2x_pix_if.sv @@
// source pixel stream channel
interface gpr2x_pix_if;
	logic                          valid;
	logic                          ready;
	logic [gpr2x_pkg::PIX_W-1:0]   pixel;

	modport source(output valid, output pixel, input ready);
	modport sink(input valid, input pixel, output ready);
endinterface

@@ rtl/gpr2x_res_if.sv @@
// destination pixel result channel
interface gpr2x_res_if;
	logic                              valid;
	logic                              ready;
	logic [gpr2x_pkg::PIX_W-1:0]       out_value;
	logic [gpr2x_pkg::DST_IDX_W-1:0]   out_row;
	logic [gpr2x_pkg::DST_IDX_W-1:0]   out_col;
	logic                              last_of_run;
	logic                              frame_done;

	modport source(output valid, output out_value, output out_row, output out_col,
		output last_of_run, output frame_done, input ready);
	modport sink(input valid, input out_value, input out_row, input out_col,
		input last_of_run, input frame_done, output ready);
endinterface

@@ rtl/gpr2x_ram.sv @@
// generic single-port-write ram with registered read
module gpr2x_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/gpr2x_expand.sv @@
// turns one destination bundle into its ordered run of result items
`include "gaussian_pyramid_reduce_2x_unit_defines.svh"

module gpr2x_expand (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                bundle_valid,
	input  gpr2x_pkg::bundle_t  bundle,
	output logic                bundle_free,
	gpr2x_res_if.source         dst
);

	typedef enum logic [1:0] {
		PH_BASE,
		PH_COL,
		PH_ROW,
		PH_CORNER
	} phase_t;

	phase_t              phase_q;
	phase_t              phase_next;
	logic                bvalid_q;
	gpr2x_pkg::bundle_t  b_q;
	logic                has_next;

	// order: base, last column copy, last row copy, corner
	always_comb begin
		has_next   = 1'b0;
		phase_next = PH_BASE;
		case (phase_q)
			PH_BASE: begin
				if (b_q.edge_col) begin
					has_next   = 1'b1;
					phase_next = PH_COL;
				end else if (b_q.edge_row) begin
					has_next   = 1'b1;
					phase_next = PH_ROW;
				end
			end
			PH_COL: begin
				if (b_q.edge_row) begin
					has_next   = 1'b1;
					phase_next = PH_ROW;
				end
			end
			PH_ROW: begin
				if (b_q.edge_col) begin
					has_next   = 1'b1;
					phase_next = PH_CORNER;
				end
			end
			default: begin
				has_next   = 1'b0;
				phase_next = PH_BASE;
			end
		endcase
	end

	assign bundle_free     = !bvalid_q || (dst.ready && !has_next);
	assign dst.valid       = bvalid_q;
	assign dst.out_value   = b_q.value;
	assign dst.out_row     = (phase_q == PH_ROW || phase_q == PH_CORNER) ? b_q.last_row : b_q.row;
	assign dst.out_col     = (phase_q == PH_COL || phase_q == PH_CORNER) ? b_q.last_col : b_q.col;
	assign dst.last_of_run = !has_next;
	assign dst.frame_done  = (phase_q == PH_CORNER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bvalid_q <= 1'b0;
			phase_q  <= PH_BASE;
		end else begin
			if (bundle_valid && bundle_free) begin
				bvalid_q <= 1'b1;
				phase_q  <= PH_BASE;
				b_q      <= bundle;
			end else if (bvalid_q && dst.ready) begin
				if (has_next) begin
					phase_q <= phase_next;
				end else begin
					bvalid_q <= 1'b0;
				end
			end
		end
	end

	`GPR2X_ASSERT_NOW(a_done_ends_run, dst.valid && dst.frame_done, dst.last_of_run,
		"frame_done without last_of_run")
	`GPR2X_ASSERT_NEXT(a_run_continues, dst.valid && dst.ready && !dst.last_of_run,
		dst.valid, "run of results broken off")
	`GPR2X_ASSERT_NOW(a_col_phase_legal, bvalid_q && (phase_q == PH_COL || phase_q == PH_CORNER),
		b_q.edge_col, "column copy emitted for an inner column")

endmodule

@@ rtl/gaussian_pyramid_reduce_2x_unit.sv @@
// top level of the 2x gaussian pyramid reduce with line buffer ram
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+-----------------------------------------------
//  src     | in  | valid/ready       | pixel[7:0]
//  dst     | out | valid/ready       | out_value, out_row, out_col, last_of_run, frame_done
//  apb     | in  | psel/penable/pwrite | paddr[2:0], pwdata/prdata[31:0], pready tied high
//
//  one pixel per cycle unless dst back-pressure stalls src; a result passes through the input
//  stage and line buffer ram read registers, then the result register in the expander
//  edge copies (up to three extra items at the frame corner) go out one per cycle, when dst is ready, while
//  later pixels keep flowing; the next result pixel is far enough away that they never stall src
//  dst back-pressure stalls src only when a pixel that yields a result waits
//  reset clears counters, window and config; the line buffer is not cleared and
//  the first two rows of each frame rewrite it
`include "gaussian_pyramid_reduce_2x_unit_defines.svh"

module gaussian_pyramid_reduce_2x_unit #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [gpr2x_pkg::APB_AW-1:0]    paddr,
	input  logic [gpr2x_pkg::APB_DW-1:0]    pwdata,
	output logic [gpr2x_pkg::APB_DW-1:0]    prdata,
	output logic                            pready,
	gpr2x_pix_if.sink                       src,
	gpr2x_res_if.source                     dst
);

	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int WW     = $clog2(MAX_WIDTH + 1);
	localparam int DIM_W  = (WW > gpr2x_pkg::CFG_W) ? WW : gpr2x_pkg::CFG_W;
	localparam int PW     = gpr2x_pkg::PIX_W;
	localparam int SW     = gpr2x_pkg::SUM_W;
	localparam int RW     = gpr2x_pkg::ROW_CNT_W;
	localparam int CFW    = gpr2x_pkg::CFG_W;
	localparam int DIW    = gpr2x_pkg::DST_IDX_W;

	logic [CFW-1:0]   width_q;
	logic [CFW-1:0]   height_q;
	logic [DIM_W-1:0] w_eff;
	logic [CFW-1:0]   h_eff;
	logic [DIM_W-1:0] dw;
	logic [CFW-1:0]   dh;

	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic             accept;

	logic             v_s1;
	logic [PW-1:0]    px_s1;
	logic [CW-1:0]    c_s1;
	logic [RW-1:0]    r_s1;
	logic [PW-1:0]    win_q [6];

	logic [2*PW-1:0]  ram_rdata;
	logic             ram_we;
	logic             ram_re;
	logic [CW-1:0]    ram_waddr;
	logic [CW-1:0]    ram_raddr;
	logic [PW-1:0]    top;
	logic [PW-1:0]    mid;

	logic [DIM_W-1:0] c_half;
	logic [CFW-1:0]   r_half;
	logic             emit_s1;
	logic             s1_adv;
	logic [SW-1:0]    sum_s1;
	logic             bundle_free;
	gpr2x_pkg::bundle_t bundle;

	// configuration registers
	assign pready = 1'b1;
	assign prdata = (paddr[2] == gpr2x_pkg::REG_SRC_HEIGHT)
		? gpr2x_pkg::APB_DW'(height_q) : gpr2x_pkg::APB_DW'(width_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= gpr2x_pkg::WIDTH_RESET;
			height_q <= gpr2x_pkg::HEIGHT_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				gpr2x_pkg::REG_SRC_WIDTH:  width_q  <= pwdata[CFW-1:0];
				gpr2x_pkg::REG_SRC_HEIGHT: height_q <= pwdata[CFW-1:0];
				default: ;
			endcase
		end
	end

	// clamp dimensions into the supported range
	always_comb begin
		if (width_q < gpr2x_pkg::DIM_MIN) begin
			w_eff = DIM_W'(gpr2x_pkg::DIM_MIN);
		end else if (DIM_W'(width_q) > DIM_W'(MAX_WIDTH)) begin
			w_eff = DIM_W'(MAX_WIDTH);
		end else begin
			w_eff = DIM_W'(width_q);
		end
		if (height_q < gpr2x_pkg::DIM_MIN) begin
			h_eff = gpr2x_pkg::DIM_MIN;
		end else if (height_q > gpr2x_pkg::HEIGHT_MAX) begin
			h_eff = gpr2x_pkg::HEIGHT_MAX;
		end else begin
			h_eff = height_q;
		end
	end

	assign dw = w_eff >> 1;
	assign dh = h_eff >> 1;

	// input side and raster counters
	assign s1_adv    = !emit_s1 || bundle_free;
	assign src.ready = !v_s1 || s1_adv;
	assign accept    = src.valid && src.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (DIM_W'(col_q) + DIM_W'(1) >= w_eff) begin
				col_q <= '0;
				row_q <= (CFW'(row_q) + CFW'(1) >= h_eff) ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1  <= 1'b1;
			px_s1 <= src.pixel;
			c_s1  <= col_q;
			r_s1  <= row_q;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	// line buffers: upper byte two rows back, lower byte one row back
	assign ram_re    = accept;
	assign ram_raddr = col_q;
	assign ram_we    = v_s1 && s1_adv;
	assign ram_waddr = c_s1;
	assign top       = ram_rdata[2*PW-1:PW];
	assign mid       = ram_rdata[PW-1:0];

	gpr2x_ram #(
		.WIDTH(2 * PW),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata({mid, px_s1}),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// window: 0..2 previous column, 3..5 the one before (top, mid, bottom)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 6; k++) begin
				win_q[k] <= '0;
			end
		end else if (v_s1 && s1_adv) begin
			win_q[3] <= win_q[0];
			win_q[4] <= win_q[1];
			win_q[5] <= win_q[2];
			win_q[0] <= top;
			win_q[1] <= mid;
			win_q[2] <= px_s1;
		end
	end

	assign sum_s1 = SW'(win_q[3]) + SW'(top) + SW'(win_q[5]) + SW'(px_s1)
		+ ((SW'(win_q[0]) + SW'(win_q[4]) + SW'(mid) + SW'(win_q[2])) << 1)
		+ (SW'(win_q[1]) << 2);

	// window centre sits at odd (r-1, c-1) when r and c are even
	assign c_half  = DIM_W'(c_s1[CW-1:1]);
	assign r_half  = CFW'(r_s1[RW-1:1]);
	assign emit_s1 = v_s1 && (r_s1 >= RW'(2)) && (c_s1 >= CW'(2)) && !r_s1[0] && !c_s1[0]
		&& (r_half + CFW'(1) <= dh) && (c_half + DIM_W'(1) <= dw);

	always_comb begin
		bundle.value    = sum_s1[SW-1:4];
		bundle.row      = DIW'(r_half - CFW'(1));
		bundle.col      = DIW'(c_half - DIM_W'(1));
		bundle.last_row = DIW'(dh - CFW'(1));
		bundle.last_col = DIW'(dw - DIM_W'(1));
		bundle.edge_row = (r_half + CFW'(1) == dh);
		bundle.edge_col = (c_half + DIM_W'(1) == dw);
	end

	gpr2x_expand u_expand (
		.clk         (clk),
		.arst_n      (arst_n),
		.bundle_valid(emit_s1),
		.bundle      (bundle),
		.bundle_free (bundle_free),
		.dst         (dst)
	);

	`GPR2X_ASSERT_NOW(a_no_rw_clash, ram_we && ram_re, ram_waddr != ram_raddr,
		"line buffer read and write hit the same entry")
	`GPR2X_ASSERT_NEXT(a_s1_hold, v_s1 && !s1_adv, v_s1 && $stable(c_s1) && $stable(px_s1),
		"stalled pixel left its stage")

endmodule

@@ verif/tb.sv @@
// self-checking testbench of the 2x gaussian pyramid reduce unit
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LINE_DEPTH   = 1024;
	localparam int unsigned DRAIN_CYCLES = 12;
	localparam int unsigned LIMIT_CYCLES = 60000;
	localparam int unsigned MAX_REPORTS  = 30;

	typedef enum {FILL_RANDOM, FILL_HIGH} fill_t;

	typedef struct packed {
		logic [gpr2x_pkg::PIX_W-1:0]     value;
		logic [gpr2x_pkg::DST_IDX_W-1:0] row;
		logic [gpr2x_pkg::DST_IDX_W-1:0] col;
		logic                            last_of_run;
		logic                            frame_done;
	} dst_pix_t;

	// predicts destination pixels from accepted source pixels and register writes
	class pyramid_reduce_check;
		logic [gpr2x_pkg::PIX_W-1:0] upper_line [LINE_DEPTH];
		logic [gpr2x_pkg::PIX_W-1:0] middle_line [LINE_DEPTH];
		logic [gpr2x_pkg::PIX_W-1:0] win [6];
		int unsigned                 col_cnt;
		int unsigned                 row_cnt;
		logic [gpr2x_pkg::CFG_W-1:0] width_reg;
		logic [gpr2x_pkg::CFG_W-1:0] height_reg;
		dst_pix_t                    expected_pixels [$];
		int unsigned                 errors;
		int unsigned                 matched;

		function new();
			foreach (upper_line[k]) begin
				upper_line[k] = '0;
				middle_line[k] = '0;
			end
			foreach (win[k])
				win[k] = '0;
			col_cnt = 0;
			row_cnt = 0;
			width_reg = gpr2x_pkg::WIDTH_RESET;
			height_reg = gpr2x_pkg::HEIGHT_RESET;
			errors = 0;
			matched = 0;
		endfunction

		function int unsigned clamp_dim(int unsigned v, int unsigned hi);
			if (v < gpr2x_pkg::DIM_MIN)
				return gpr2x_pkg::DIM_MIN;
			if (v > hi)
				return hi;
			return v;
		endfunction

		function int unsigned pending();
			return expected_pixels.size();
		endfunction

		function void take_reg_write(logic idx, logic [gpr2x_pkg::APB_DW-1:0] data);
			if (idx == gpr2x_pkg::REG_SRC_WIDTH)
				width_reg = data[gpr2x_pkg::CFG_W-1:0];
			else
				height_reg = data[gpr2x_pkg::CFG_W-1:0];
		endfunction

		function void predict_pixel(logic [gpr2x_pkg::PIX_W-1:0] px);
			int unsigned w, h, dw, dh, c, r, ci, i, j, sum;
			logic [gpr2x_pkg::PIX_W-1:0] top, mid, v;
			bit lastc, lastr;
			dst_pix_t run [$];
			w = clamp_dim(width_reg, LINE_DEPTH);
			h = clamp_dim(height_reg, gpr2x_pkg::HEIGHT_MAX);
			dw = w / 2;
			dh = h / 2;
			c = col_cnt;
			r = row_cnt;
			ci = (c < LINE_DEPTH) ? c : 0;
			top = upper_line[ci];
			mid = middle_line[ci];
			if (c < LINE_DEPTH) begin
				upper_line[ci] = mid;
				middle_line[ci] = px;
			end
			// window centre sits one row and one column behind the arriving pixel
			if (r >= 2 && c >= 2 && (r % 2) == 0 && (c % 2) == 0) begin
				i = (r - 2) / 2;
				j = (c - 2) / 2;
				if (i + 2 <= dh && j + 2 <= dw) begin
					sum = win[3] + top + win[5] + px
						+ 2 * (win[0] + win[4] + mid + win[2])
						+ 4 * win[1];
					v = sum >> 4;
					lastc = (j + 2 == dw);
					lastr = (i + 2 == dh);
					run.push_back('{v, gpr2x_pkg::DST_IDX_W'(i), gpr2x_pkg::DST_IDX_W'(j),
						1'b0, 1'b0});
					if (lastc)
						run.push_back('{v, gpr2x_pkg::DST_IDX_W'(i),
							gpr2x_pkg::DST_IDX_W'(dw - 1), 1'b0, 1'b0});
					if (lastr)
						run.push_back('{v, gpr2x_pkg::DST_IDX_W'(dh - 1),
							gpr2x_pkg::DST_IDX_W'(j), 1'b0, 1'b0});
					if (lastc && lastr)
						run.push_back('{v, gpr2x_pkg::DST_IDX_W'(dh - 1),
							gpr2x_pkg::DST_IDX_W'(dw - 1), 1'b0, 1'b1});
					run[run.size() - 1].last_of_run = 1'b1;
					foreach (run[k])
						expected_pixels.push_back(run[k]);
				end
			end
			win[3] = win[0];
			win[4] = win[1];
			win[5] = win[2];
			win[0] = top;
			win[1] = mid;
			win[2] = px;
			if (c + 1 >= w) begin
				col_cnt = 0;
				row_cnt = (r + 1 >= h) ? 0 : r + 1;
			end else begin
				col_cnt = c + 1;
			end
		endfunction

		function void report(string field, int unsigned want,
			logic [gpr2x_pkg::DST_IDX_W-1:0] got);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		endfunction

		function void check_pixel(dst_pix_t got);
			dst_pix_t want;
			if (expected_pixels.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected dst item, expected none, actual row %0d col %0d value %0d",
						$time, got.row, got.col, got.value);
				return;
			end
			want = expected_pixels.pop_front();
			if (got.value !== want.value)
				report("out_value", want.value, got.value);
			if (got.row !== want.row)
				report("out_row", want.row, got.row);
			if (got.col !== want.col)
				report("out_col", want.col, got.col);
			if (got.last_of_run !== want.last_of_run)
				report("last_of_run", want.last_of_run, got.last_of_run);
			if (got.frame_done !== want.frame_done)
				report("frame_done", want.frame_done, got.frame_done);
			matched++;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [gpr2x_pkg::APB_AW-1:0] paddr;
	logic [gpr2x_pkg::APB_DW-1:0] pwdata;
	logic [gpr2x_pkg::APB_DW-1:0] prdata;
	logic pready;

	gpr2x_pix_if src_ch();
	gpr2x_res_if dst_ch();

	gaussian_pyramid_reduce_2x_unit #(
		.MAX_WIDTH(LINE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.src(src_ch),
		.dst(dst_ch)
	);

	pyramid_reduce_check pyr = new();

	bit          src_idle_on;
	bit          dst_idle_on;
	int unsigned stall_left;
	int unsigned cycles;
	int unsigned pixels_sent;
	int unsigned settings_used;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// result side back-pressure in random bursts
	always @(negedge clk) begin
		if (stall_left == 0 && dst_idle_on && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 14);
		if (stall_left > 0) begin
			dst_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			dst_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && dst_ch.valid === 1'b1 && dst_ch.ready === 1'b1)
			pyr.check_pixel(dst_pix_t'{dst_ch.out_value, dst_ch.out_row, dst_ch.out_col,
				dst_ch.last_of_run, dst_ch.frame_done});
	end

	function automatic logic [gpr2x_pkg::PIX_W-1:0] random_pixel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return gpr2x_pkg::PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic reg_write(input logic idx, input int unsigned value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		// upper bits are junk the register must drop
		pwdata <= ($urandom() & 32'hFFFF_F800) | (value & 32'h7FF);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		pyr.take_reg_write(idx, pwdata);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_frame(input int unsigned w, input int unsigned h);
		reg_write(gpr2x_pkg::REG_SRC_WIDTH, w);
		reg_write(gpr2x_pkg::REG_SRC_HEIGHT, h);
		settings_used++;
	endtask

	task automatic push_pixel(input logic [gpr2x_pkg::PIX_W-1:0] px);
		int unsigned gap;
		gap = (src_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
		@(negedge clk);
		if (gap > 0) begin
			src_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		src_ch.valid <= 1'b1;
		src_ch.pixel <= px;
		do @(posedge clk); while (src_ch.ready !== 1'b1);
		pyr.predict_pixel(px);
		pixels_sent++;
	endtask

	task automatic send_pixels(input int unsigned n, input fill_t fill);
		for (int unsigned k = 0; k < n; k++) begin
			case (fill)
				FILL_HIGH: push_pixel('1);
				default:   push_pixel(random_pixel());
			endcase
		end
		@(negedge clk);
		src_ch.valid <= 1'b0;
	endtask

	task automatic drain();
		while (pyr.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		src_ch.valid = 1'b0;
		src_ch.pixel = '0;
		dst_ch.ready = 1'b0;
		stall_left = 0;
		src_idle_on = 1'b0;
		dst_idle_on = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// width under the minimum and height over the maximum clamp, saturated rows first
		src_idle_on = 1'b1;
		dst_idle_on = 1'b1;
		set_frame(3, 2047);
		send_pixels(40, FILL_HIGH);
		drain();

		// height lowered mid-frame while the row count is still inside it
		reg_write(gpr2x_pkg::REG_SRC_HEIGHT, 5);
		send_pixels(24, FILL_RANDOM);
		drain();

		// closing stretch at full rate, odd width leaves the last column unused
		src_idle_on = 1'b0;
		dst_idle_on = 1'b0;
		set_frame(9, 8);
		send_pixels(63, FILL_RANDOM);
		drain();

		$display("source pixels sent: %0d, destination pixels checked: %0d, frame sizes: %0d",
			pixels_sent, pyr.matched, settings_used);
		$display("covered clamped sizes, a mid-frame height change, saturated input, odd width");
		if (pyr.errors == 0 && pyr.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/gpr2x_pkg.sv
rtl/gpr2x_pix_if.sv
rtl/gpr2x_res_if.sv
rtl/gpr2x_ram.sv
rtl/gpr2x_expand.sv
rtl/gaussian_pyramid_reduce_2x_unit.sv
verif/tb.sv
